@@ src/pmu_pkg.sv @@
// Shared types and constants for the particle motion update pipeline.
// No dependencies; every other file in src uses this package.
`default_nettype none

package pmu_pkg;

  localparam int DW   = 32;          // data word width, signed fixed point
  localparam int FB   = 16;          // fraction bits of a data word
  localparam int CW   = 17;          // coefficient register width
  localparam int CB   = 16;          // coefficient fraction bits (root is CB wide, FB == CB)
  localparam int RTW  = FB;          // square root result bits
  localparam int REMW = RTW + 2;     // partial remainder of the root chain
  localparam int RADW = 2 * FB;      // radicand bits below 1.0 squared
  localparam int SQW  = 2 * FB + 1;  // one square, at most 1.0 squared
  localparam int NCELL = RTW;        // one root cell per result bit

  typedef logic [DW-1:0] data_t;
  typedef logic [CW-1:0] coef_t;

  localparam coef_t COEF_ONE   = CW'(1) << CB;
  localparam coef_t DAMP_RST   = CW'(58982);
  localparam coef_t DECAY_RST  = CW'(52429);
  localparam coef_t DIM_RST    = CW'(6554);

  typedef enum logic [1:0] {
    REG_DAMP  = 2'd0,
    REG_DECAY = 2'd1,
    REG_DIM   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    data_t [2:0] pos;
    data_t [2:0] vel;
    data_t [2:0] acc;
  } kin_t;

  typedef struct packed {
    logic            clamp;
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [RTW-1:0]  root;
    kin_t            kin;
  } sq_word_t;

endpackage

`default_nettype wire

@@ src/pmu_front.sv @@
// Kinematic stages: position add, damped velocity, decayed acceleration,
// squares and sum of squares. Uses pmu_pkg; feeds the root cell chain.
`default_nettype none

module pmu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pmu_pkg::kin_t      in_kin,
  input  pmu_pkg::coef_t     damp,
  input  pmu_pkg::coef_t     decay,
  output logic               out_valid,
  output pmu_pkg::sq_word_t  out_word
);

  localparam int PW   = pmu_pkg::DW + pmu_pkg::CW;  // magnitude times coefficient
  localparam int RW   = PW - pmu_pkg::CB;           // rounded magnitude
  localparam int SW   = RW + 2;                     // signed sum before saturation
  localparam int SUMW = pmu_pkg::SQW + 2;
  localparam int SQF  = 2 * (pmu_pkg::FB + 1);

  localparam logic signed [SW-1:0] DMAX = {{(SW-pmu_pkg::DW+1){1'b0}}, {(pmu_pkg::DW-1){1'b1}}};
  localparam logic signed [SW-1:0] DMIN = {{(SW-pmu_pkg::DW+1){1'b1}}, {(pmu_pkg::DW-1){1'b0}}};
  localparam logic [PW-1:0]        HALF = PW'(1) << (pmu_pkg::CB - 1);

  function automatic pmu_pkg::data_t sat(input logic signed [SW-1:0] v);
    if (v > DMAX) begin
      return DMAX[pmu_pkg::DW-1:0];
    end else if (v < DMIN) begin
      return DMIN[pmu_pkg::DW-1:0];
    end
    return v[pmu_pkg::DW-1:0];
  endfunction

  // stage 1: magnitudes times coefficients, position sum
  logic                        s1_valid_r;
  pmu_pkg::data_t [2:0]        s1_pos_r, s1_pos_nxt;
  pmu_pkg::data_t [2:0]        s1_acc_r;
  logic [2:0]                  s1_vneg_r, s1_aneg_r;
  logic [2:0][PW-1:0]          s1_vprod_r, s1_vprod_nxt, s1_aprod_r, s1_aprod_nxt;

  // stage 2: rounding
  logic                        s2_valid_r;
  pmu_pkg::data_t [2:0]        s2_pos_r, s2_acc_r;
  logic [2:0]                  s2_vneg_r, s2_aneg_r;
  logic [2:0][RW-1:0]          s2_vr_r, s2_vr_nxt, s2_ar_r, s2_ar_nxt;

  // stage 3: add acceleration, saturate
  logic                        s3_valid_r;
  pmu_pkg::kin_t               s3_kin_r, s3_kin_nxt;

  // stage 4: squares
  logic                        s4_valid_r;
  pmu_pkg::kin_t               s4_kin_r;
  logic                        s4_big_r, s4_big_nxt;
  logic [2:0][pmu_pkg::SQW-1:0] s4_sq_r, s4_sq_nxt;

  // stage 5: sum of squares
  logic                        s5_valid_r;
  pmu_pkg::sq_word_t           s5_word_r, s5_word_nxt;

  always_comb begin
    pmu_pkg::data_t vmag, amag;
    logic signed [SW-1:0] ps;
    for (int k = 0; k < 3; k++) begin
      vmag = in_kin.vel[k][pmu_pkg::DW-1] ? (~in_kin.vel[k] + 1'b1) : in_kin.vel[k];
      amag = in_kin.acc[k][pmu_pkg::DW-1] ? (~in_kin.acc[k] + 1'b1) : in_kin.acc[k];
      s1_vprod_nxt[k] = PW'(vmag) * PW'(damp);
      s1_aprod_nxt[k] = PW'(amag) * PW'(decay);
      ps = SW'(signed'(in_kin.pos[k])) + SW'(signed'(in_kin.vel[k]));
      s1_pos_nxt[k] = sat(ps);
    end
  end

  always_comb begin
    logic [PW-1:0] tv, ta;
    for (int k = 0; k < 3; k++) begin
      tv = s1_vprod_r[k] + HALF;
      ta = s1_aprod_r[k] + HALF;
      s2_vr_nxt[k] = tv[PW-1:pmu_pkg::CB];
      s2_ar_nxt[k] = ta[PW-1:pmu_pkg::CB];
    end
  end

  always_comb begin
    logic signed [SW-1:0] a, r, v, q;
    s3_kin_nxt.pos = s2_pos_r;
    for (int k = 0; k < 3; k++) begin
      a = SW'(signed'(s2_acc_r[k]));
      r = signed'({2'b00, s2_vr_r[k]});
      v = s2_vneg_r[k] ? (a - r) : (a + r);
      s3_kin_nxt.vel[k] = sat(v);
      q = signed'({2'b00, s2_ar_r[k]});
      s3_kin_nxt.acc[k] = sat(s2_aneg_r[k] ? -q : q);
    end
  end

  // only velocities within +-1.0 need a square; anything else clamps the brightness
  always_comb begin
    logic [pmu_pkg::DW-pmu_pkg::FB-1:0] hi;
    logic signed [pmu_pkg::FB:0]        sv;
    logic signed [SQF-1:0]              sq;
    s4_big_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      hi = s3_kin_r.vel[k][pmu_pkg::DW-1:pmu_pkg::FB];
      if (!((&hi) || !(|hi))) begin
        s4_big_nxt = 1'b1;
      end
      sv = signed'(s3_kin_r.vel[k][pmu_pkg::FB:0]);
      sq = sv * sv;
      s4_sq_nxt[k] = sq[pmu_pkg::SQW-1:0];
    end
  end

  always_comb begin
    logic [SUMW-1:0] sum;
    sum = SUMW'(s4_sq_r[0]) + SUMW'(s4_sq_r[1]) + SUMW'(s4_sq_r[2]);
    s5_word_nxt.clamp = s4_big_r || (|sum[SUMW-1:pmu_pkg::RADW]);
    s5_word_nxt.rad   = sum[pmu_pkg::RADW-1:0];
    s5_word_nxt.rem   = '0;
    s5_word_nxt.root  = '0;
    s5_word_nxt.kin   = s4_kin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_vneg_r[k] <= in_kin.vel[k][pmu_pkg::DW-1];
      s1_aneg_r[k] <= in_kin.acc[k][pmu_pkg::DW-1];
    end
    s1_pos_r   <= s1_pos_nxt;
    s1_acc_r   <= in_kin.acc;
    s1_vprod_r <= s1_vprod_nxt;
    s1_aprod_r <= s1_aprod_nxt;

    s2_pos_r  <= s1_pos_r;
    s2_acc_r  <= s1_acc_r;
    s2_vneg_r <= s1_vneg_r;
    s2_aneg_r <= s1_aneg_r;
    s2_vr_r   <= s2_vr_nxt;
    s2_ar_r   <= s2_ar_nxt;

    s3_kin_r <= s3_kin_nxt;

    s4_kin_r <= s3_kin_r;
    s4_big_r <= s4_big_nxt;
    s4_sq_r  <= s4_sq_nxt;

    s5_word_r <= s5_word_nxt;
  end

  assign out_valid = s5_valid_r;
  assign out_word  = s5_word_r;

endmodule

`default_nettype wire

@@ src/pmu_sqrt_cell.sv @@
// One cell of the square root chain: settles one root bit per cell.
// Uses pmu_pkg; instanced in a row by the top level.
`default_nettype none

module pmu_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pmu_pkg::sq_word_t  in_word,
  output logic               out_valid,
  output pmu_pkg::sq_word_t  out_word
);

  localparam int AW = pmu_pkg::REMW + 2;

  logic              valid_r;
  pmu_pkg::sq_word_t word_r, word_nxt;

  // restoring digit step: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [AW-1:0] acc, trial, diff;
    acc   = {in_word.rem, in_word.rad[pmu_pkg::RADW-1 -: 2]};
    trial = AW'({in_word.root, 2'b01});
    diff  = acc - trial;
    word_nxt     = in_word;
    word_nxt.rad = in_word.rad << 2;
    if (acc >= trial) begin
      word_nxt.rem  = diff[pmu_pkg::REMW-1:0];
      word_nxt.root = {in_word.root[pmu_pkg::RTW-2:0], 1'b1};
    end else begin
      word_nxt.rem  = acc[pmu_pkg::REMW-1:0];
      word_nxt.root = {in_word.root[pmu_pkg::RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

@@ src/pmu_shade.sv @@
// Brightness clamp and grey shade blend, two stages, registered result word.
// Uses pmu_pkg; takes the word leaving the last root cell.
`default_nettype none

module pmu_shade (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pmu_pkg::sq_word_t  in_word,
  input  pmu_pkg::coef_t     dim,
  output logic               out_valid,
  output pmu_pkg::kin_t      out_kin,
  output pmu_pkg::coef_t     out_shade
);

  localparam int MW = 2 * pmu_pkg::CW;
  localparam int TW = MW + 1;

  logic            a_valid_r;
  pmu_pkg::kin_t   a_kin_r;
  pmu_pkg::coef_t  a_b_r, a_b_nxt;
  logic [MW-1:0]   a_prod_r, a_prod_nxt;

  logic            b_valid_r;
  pmu_pkg::kin_t   b_kin_r;
  pmu_pkg::coef_t  b_shade_r, b_shade_nxt;

  always_comb begin
    a_b_nxt    = in_word.clamp ? pmu_pkg::COEF_ONE : pmu_pkg::CW'(in_word.root);
    a_prod_nxt = MW'(dim) * MW'(pmu_pkg::COEF_ONE - a_b_nxt);
  end

  // dim*(1-b) + b, rounded half up, capped at 1.0
  always_comb begin
    logic [TW-1:0] tot, sh;
    tot = TW'(a_prod_r) + (TW'(a_b_r) << pmu_pkg::CB) + (TW'(1) << (pmu_pkg::CB - 1));
    sh  = tot >> pmu_pkg::CB;
    if (sh > TW'(pmu_pkg::COEF_ONE)) begin
      b_shade_nxt = pmu_pkg::COEF_ONE;
    end else begin
      b_shade_nxt = sh[pmu_pkg::CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_kin_r   <= in_word.kin;
    a_b_r     <= a_b_nxt;
    a_prod_r  <= a_prod_nxt;
    b_kin_r   <= a_kin_r;
    b_shade_r <= b_shade_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_kin   = b_kin_r;
  assign out_shade = b_shade_r;

endmodule

`default_nettype wire

@@ src/particle_motion_update.sv @@
// Top level of the particle motion update pipeline.
// Uses pmu_pkg, pmu_front, pmu_sqrt_cell and pmu_shade.
`default_nettype none

// One particle per clock: busy stays low, so a word is taken at every edge with
// start high. Each result word appears for a single cycle marked by out_valid;
// the receiver cannot stall it. The pipeline is five kinematic stages (multiply,
// round, add and saturate, square, sum), a row of 16 square root cells settling
// one root bit each, and two shade stages.
// Write the coefficient registers only with the pipeline empty, i.e. 23 or
// more cycles after the last start; unknown register indexes are ignored.
module particle_motion_update (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [pmu_pkg::DW-1:0]    in_pos_x,
  input  logic signed [pmu_pkg::DW-1:0]    in_pos_y,
  input  logic signed [pmu_pkg::DW-1:0]    in_pos_z,
  input  logic signed [pmu_pkg::DW-1:0]    in_vel_x,
  input  logic signed [pmu_pkg::DW-1:0]    in_vel_y,
  input  logic signed [pmu_pkg::DW-1:0]    in_vel_z,
  input  logic signed [pmu_pkg::DW-1:0]    in_acc_x,
  input  logic signed [pmu_pkg::DW-1:0]    in_acc_y,
  input  logic signed [pmu_pkg::DW-1:0]    in_acc_z,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [pmu_pkg::CW-1:0]           cfg_wdata,
  output logic                             out_valid,
  output logic signed [pmu_pkg::DW-1:0]    out_new_pos_x,
  output logic signed [pmu_pkg::DW-1:0]    out_new_pos_y,
  output logic signed [pmu_pkg::DW-1:0]    out_new_pos_z,
  output logic signed [pmu_pkg::DW-1:0]    out_new_vel_x,
  output logic signed [pmu_pkg::DW-1:0]    out_new_vel_y,
  output logic signed [pmu_pkg::DW-1:0]    out_new_vel_z,
  output logic signed [pmu_pkg::DW-1:0]    out_new_acc_x,
  output logic signed [pmu_pkg::DW-1:0]    out_new_acc_y,
  output logic signed [pmu_pkg::DW-1:0]    out_new_acc_z,
  output logic [pmu_pkg::CW-1:0]           out_shade
);

  pmu_pkg::coef_t damp_r, decay_r, dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r  <= pmu_pkg::DAMP_RST;
      decay_r <= pmu_pkg::DECAY_RST;
      dim_r   <= pmu_pkg::DIM_RST;
    end else if (cfg_we) begin
      unique case (pmu_pkg::reg_idx_t'(cfg_index))
        pmu_pkg::REG_DAMP:  damp_r  <= cfg_wdata;
        pmu_pkg::REG_DECAY: decay_r <= cfg_wdata;
        pmu_pkg::REG_DIM:   dim_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  pmu_pkg::kin_t in_kin;

  always_comb begin
    in_kin.pos[0] = in_pos_x;
    in_kin.pos[1] = in_pos_y;
    in_kin.pos[2] = in_pos_z;
    in_kin.vel[0] = in_vel_x;
    in_kin.vel[1] = in_vel_y;
    in_kin.vel[2] = in_vel_z;
    in_kin.acc[0] = in_acc_x;
    in_kin.acc[1] = in_acc_y;
    in_kin.acc[2] = in_acc_z;
  end

  logic              chain_valid [pmu_pkg::NCELL+1];
  pmu_pkg::sq_word_t chain_word  [pmu_pkg::NCELL+1];

  pmu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_kin    (in_kin),
    .damp      (damp_r),
    .decay     (decay_r),
    .out_valid (chain_valid[0]),
    .out_word  (chain_word[0])
  );

  for (genvar i = 0; i < pmu_pkg::NCELL; i++) begin : g_cell
    pmu_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  pmu_pkg::kin_t out_kin;

  pmu_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[pmu_pkg::NCELL]),
    .in_word   (chain_word[pmu_pkg::NCELL]),
    .dim       (dim_r),
    .out_valid (out_valid),
    .out_kin   (out_kin),
    .out_shade (out_shade)
  );

  assign out_new_pos_x = out_kin.pos[0];
  assign out_new_pos_y = out_kin.pos[1];
  assign out_new_pos_z = out_kin.pos[2];
  assign out_new_vel_x = out_kin.vel[0];
  assign out_new_vel_y = out_kin.vel[1];
  assign out_new_vel_z = out_kin.vel[2];
  assign out_new_acc_x = out_kin.acc[0];
  assign out_new_acc_y = out_kin.acc[1];
  assign out_new_acc_z = out_kin.acc[2];

endmodule

`default_nettype wire
